// ===== src/akf_pkg.sv =====
// ----------------------------------------------------------------------------
// akf_pkg
// Shared widths, register indexes, control word types and the microcode
// program of the angle Kalman filter.
// ----------------------------------------------------------------------------
package akf_pkg;

   localparam int ANGLE_W     = 32;
   localparam int DT_W        = 16;
   localparam int NOISE_W     = 24;
   localparam int COV_W       = 32;
   localparam int GAIN_W      = 32;
   localparam int CSR_INDEX_W = 4;
   localparam int STEP_W      = 4;
   localparam int MUL_A_W     = 33;
   localparam int MUL_B_W     = 36;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_NOISE     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASUREMENT_NOISE = CSR_INDEX_W'(1);

   localparam logic [NOISE_W-1:0] PROCESS_NOISE_RESET     = NOISE_W'(16777);
   localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RESET = NOISE_W'(503316);

   typedef enum logic [2:0] {
      MUL_DT_P11,
      MUL_DT_INNER,
      MUL_K0_Y,
      MUL_K1_P00,
      MUL_K1_P01,
      MUL_K0_P00,
      MUL_K0_P01,
      MUL_NONE
   } akf_mul_sel_type;

   typedef enum logic [3:0] {
      WB_NONE,
      WB_A,
      WB_PRED,
      WB_P00_PRED,
      WB_ANGLE,
      WB_P10_UPD,
      WB_P11_UPD,
      WB_P00_UPD,
      WB_P01_UPD
   } akf_wb_sel_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_DIV_BUSY,
      COND_OUT_FULL
   } akf_cond_type;

   typedef struct packed {
      akf_mul_sel_type     mul_sel;
      akf_wb_sel_type      wb_sel;
      logic                div_start;
      logic                finish;
      akf_cond_type        cond;
      logic [STEP_W-1:0]   target;
   } akf_uword_type;

   typedef struct packed {
      logic                      busy;
      logic signed [GAIN_W-1:0]  k0;
      logic signed [GAIN_W-1:0]  k1;
   } akf_div_status_type;

   // Program: predict (steps 0-4), gain division (5-6), update (7-12), result (13).
   // A step issues a product and writes back the one issued by the step before.
   function automatic akf_uword_type akf_ucode(input logic [STEP_W-1:0] step);
      akf_uword_type w;
      w.mul_sel   = MUL_NONE;
      w.wb_sel    = WB_NONE;
      w.div_start = 1'b0;
      w.finish    = 1'b0;
      w.cond      = COND_NONE;
      w.target    = step;
      unique case (step)
         STEP_W'(0):  w.mul_sel = MUL_DT_P11;
         STEP_W'(1):  w.wb_sel  = WB_A;
         STEP_W'(2):  w.wb_sel  = WB_PRED;
         STEP_W'(3):  w.mul_sel = MUL_DT_INNER;
         STEP_W'(4):  w.wb_sel  = WB_P00_PRED;
         STEP_W'(5):  w.div_start = 1'b1;
         STEP_W'(6):  w.cond    = COND_DIV_BUSY;
         STEP_W'(7):  w.mul_sel = MUL_K0_Y;
         STEP_W'(8): begin
            w.wb_sel  = WB_ANGLE;
            w.mul_sel = MUL_K1_P00;
         end
         STEP_W'(9): begin
            w.wb_sel  = WB_P10_UPD;
            w.mul_sel = MUL_K1_P01;
         end
         STEP_W'(10): begin
            w.wb_sel  = WB_P11_UPD;
            w.mul_sel = MUL_K0_P00;
         end
         STEP_W'(11): begin
            w.wb_sel  = WB_P00_UPD;
            w.mul_sel = MUL_K0_P01;
         end
         STEP_W'(12): w.wb_sel = WB_P01_UPD;
         STEP_W'(13): begin
            w.cond   = COND_OUT_FULL;
            w.finish = 1'b1;
         end
         default: w.target = '0;
      endcase
      return w;
   endfunction

endpackage

// ===== src/akf_gain_div.sv =====
// ----------------------------------------------------------------------------
// akf_gain_div
// Two-lane radix-2 divider for the Kalman gains K0 = (P00 << 24) / S and
// K1 = (P10 << 24) / S with S = P00 + R, truncated and saturated to Q8.24.
// ----------------------------------------------------------------------------
module akf_gain_div
   import akf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [COV_W-1:0]    p00,
   input  logic signed [COV_W-1:0]    p10,
   input  logic [NOISE_W-1:0]         meas_noise,
   output akf_div_status_type         status
);

   localparam int S_W   = COV_W + 1;
   localparam int REM_W = S_W;
   localparam int Q_W   = GAIN_W - 1;
   localparam int LOW_W = Q_W;
   localparam int PRE_W = LOW_W - (GAIN_W - 8);
   localparam int CNT_W = 5;

   localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
   localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_SETUP,
      DIV_ITER,
      DIV_FINISH
   } div_state_type;

   div_state_type state_ff, state_in;

   logic signed [S_W-1:0]    s_ff, s_in;
   logic signed [COV_W-1:0]  n0_ff, n0_in, n1_ff, n1_in;
   logic [S_W-1:0]           den_ff, den_in;
   logic                     zero_ff, zero_in;
   logic                     neg0_ff, neg0_in, neg1_ff, neg1_in;
   logic                     ovf0_ff, ovf0_in, ovf1_ff, ovf1_in;
   logic [REM_W-1:0]         rem0_ff, rem0_in, rem1_ff, rem1_in;
   logic [LOW_W-1:0]         low0_ff, low0_in, low1_ff, low1_in;
   logic [Q_W-1:0]           q0_ff, q0_in, q1_ff, q1_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [GAIN_W-1:0] k0_ff, k0_in, k1_ff, k1_in;

   logic                     s_neg;
   logic [S_W-1:0]           den_mag;
   logic [COV_W-1:0]         mag0, mag1;
   logic [REM_W:0]           step0, step1;

   // One restoring step: returns {new remainder, quotient bit}.
   function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                                input logic bit_in,
                                                input logic [S_W-1:0] den);
      logic [REM_W:0] sh;
      logic [REM_W:0] diff;
      sh   = {rem, bit_in};
      diff = sh - {1'b0, den};
      if (sh >= {1'b0, den}) begin
         return {diff[REM_W-1:0], 1'b1};
      end
      return {sh[REM_W-1:0], 1'b0};
   endfunction

   function automatic logic signed [GAIN_W-1:0] gain_pick(input logic zero,
                                                          input logic ovf,
                                                          input logic neg,
                                                          input logic [Q_W-1:0] q);
      logic signed [GAIN_W-1:0] qs;
      qs = $signed({1'b0, q});
      if (zero) begin
         return '0;
      end
      if (ovf) begin
         return neg ? GAIN_MIN : GAIN_MAX;
      end
      return neg ? -qs : qs;
   endfunction

   always_comb begin
      s_neg   = s_ff[S_W-1];
      den_mag = s_neg ? S_W'(-s_ff) : S_W'(s_ff);
      mag0    = n0_ff[COV_W-1] ? COV_W'(-n0_ff) : COV_W'(n0_ff);
      mag1    = n1_ff[COV_W-1] ? COV_W'(-n1_ff) : COV_W'(n1_ff);
      step0   = div_step(rem0_ff, low0_ff[LOW_W-1], den_ff);
      step1   = div_step(rem1_ff, low1_ff[LOW_W-1], den_ff);

      state_in = state_ff;
      s_in     = s_ff;
      n0_in    = n0_ff;
      n1_in    = n1_ff;
      den_in   = den_ff;
      zero_in  = zero_ff;
      neg0_in  = neg0_ff;
      neg1_in  = neg1_ff;
      ovf0_in  = ovf0_ff;
      ovf1_in  = ovf1_ff;
      rem0_in  = rem0_ff;
      rem1_in  = rem1_ff;
      low0_in  = low0_ff;
      low1_in  = low1_ff;
      q0_in    = q0_ff;
      q1_in    = q1_ff;
      cnt_in   = cnt_ff;
      k0_in    = k0_ff;
      k1_in    = k1_ff;

      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               s_in     = S_W'(p00) + $signed({{(S_W-NOISE_W){1'b0}}, meas_noise});
               n0_in    = p00;
               n1_in    = p10;
               state_in = DIV_SETUP;
            end
         end
         DIV_SETUP: begin
            // Quotient overflows 31 bits when |P| << 24 >= |S| << 31.
            den_in   = den_mag;
            zero_in  = (s_ff == '0);
            neg0_in  = n0_ff[COV_W-1] ^ s_neg;
            neg1_in  = n1_ff[COV_W-1] ^ s_neg;
            ovf0_in  = {8'b0, mag0} >= {den_mag, 7'b0};
            ovf1_in  = {8'b0, mag1} >= {den_mag, 7'b0};
            rem0_in  = REM_W'(mag0[COV_W-1:PRE_W]);
            rem1_in  = REM_W'(mag1[COV_W-1:PRE_W]);
            low0_in  = {mag0[PRE_W-1:0], {(LOW_W-PRE_W){1'b0}}};
            low1_in  = {mag1[PRE_W-1:0], {(LOW_W-PRE_W){1'b0}}};
            q0_in    = '0;
            q1_in    = '0;
            cnt_in   = CNT_W'(Q_W - 1);
            state_in = DIV_ITER;
         end
         DIV_ITER: begin
            rem0_in = step0[REM_W:1];
            rem1_in = step1[REM_W:1];
            q0_in   = {q0_ff[Q_W-2:0], step0[0]};
            q1_in   = {q1_ff[Q_W-2:0], step1[0]};
            low0_in = {low0_ff[LOW_W-2:0], 1'b0};
            low1_in = {low1_ff[LOW_W-2:0], 1'b0};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = DIV_FINISH;
            end
         end
         DIV_FINISH: begin
            k0_in    = gain_pick(zero_ff, ovf0_ff, neg0_ff, q0_ff);
            k1_in    = gain_pick(zero_ff, ovf1_ff, neg1_ff, q1_ff);
            state_in = DIV_IDLE;
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      s_ff    <= s_in;
      n0_ff   <= n0_in;
      n1_ff   <= n1_in;
      den_ff  <= den_in;
      zero_ff <= zero_in;
      neg0_ff <= neg0_in;
      neg1_ff <= neg1_in;
      ovf0_ff <= ovf0_in;
      ovf1_ff <= ovf1_in;
      rem0_ff <= rem0_in;
      rem1_ff <= rem1_in;
      low0_ff <= low0_in;
      low1_ff <= low1_in;
      q0_ff   <= q0_in;
      q1_ff   <= q1_in;
      cnt_ff  <= cnt_in;
      k0_ff   <= k0_in;
      k1_ff   <= k1_in;
   end

   assign status.busy = (state_ff != DIV_IDLE);
   assign status.k0   = k0_ff;
   assign status.k1   = k1_ff;

endmodule

// ===== src/angle_kalman_filter_top.sv =====
// Flow: an accepted request runs 14 program steps to rsp_valid, one of which
//    waits on the gain divider.
// Occupancy: no request is taken until the program ends; the divider loop and
//    the single shared multiplier, driven step by step by microcode, set this.
// Reset: clears the angle estimate and covariance, loads the default noise
//    registers, and the block is ready for a request in the next cycle.
// ----------------------------------------------------------------------------
// angle_kalman_filter_top
// Microcoded fixed-point Kalman filter for a tilt angle without a gyro input.
// ----------------------------------------------------------------------------
module angle_kalman_filter_top
   import akf_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [ANGLE_W-1:0]   req_measured_angle,
   input  logic [DT_W-1:0]             req_time_step,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [ANGLE_W-1:0]   rsp_filtered_angle,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [NOISE_W-1:0]          csr_data
);

   localparam logic signed [PROD_W-1:0] RND16_HALF = PROD_W'(1) <<< 15;
   localparam logic signed [PROD_W-1:0] RND24_HALF = PROD_W'(1) <<< 23;
   localparam logic signed [PROD_W-1:0] SAT_MAX =
      {{(PROD_W-ANGLE_W+1){1'b0}}, {(ANGLE_W-1){1'b1}}};
   localparam logic signed [PROD_W-1:0] SAT_MIN =
      {{(PROD_W-ANGLE_W+1){1'b1}}, {(ANGLE_W-1){1'b0}}};

   function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      if (v > SAT_MAX) begin
         return SAT_MAX[ANGLE_W-1:0];
      end
      if (v < SAT_MIN) begin
         return SAT_MIN[ANGLE_W-1:0];
      end
      return v[ANGLE_W-1:0];
   endfunction

   // control
   logic                     active_ff, active_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_W-1:0] rsp_angle_ff, rsp_angle_in;

   // configuration
   logic [NOISE_W-1:0]       process_noise_ff, process_noise_in;
   logic [NOISE_W-1:0]       meas_noise_ff, meas_noise_in;

   // filter state
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;
   logic signed [COV_W-1:0]   p00_ff, p00_in, p01_ff, p01_in;
   logic signed [COV_W-1:0]   p10_ff, p10_in, p11_ff, p11_in;

   // working registers
   logic [DT_W-1:0]            dt_ff, dt_in;
   logic signed [ANGLE_W-1:0]  meas_ff, meas_in;
   logic signed [COV_W-1:0]    a_ff, a_in;
   logic signed [MUL_B_W-1:0]  inner_ff, inner_in;
   logic signed [ANGLE_W-1:0]  y_ff, y_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;

   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   rnd16, rnd24;
   logic signed [MUL_A_W-1:0]  dt_op;

   akf_uword_type       uword;
   akf_div_status_type  div_status;
   logic                accept;
   logic                cond_true;

   akf_gain_div u_gain_div (
      .clock      (clock),
      .reset      (reset),
      .start      (active_ff && uword.div_start),
      .p00        (p00_ff),
      .p10        (p10_ff),
      .meas_noise (meas_noise_ff),
      .status     (div_status)
   );

   assign accept    = req_valid && !active_ff;
   assign uword     = akf_ucode(step_ff);
   assign req_stall = active_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_filtered_angle = rsp_angle_ff;

   // sequencer
   always_comb begin
      unique case (uword.cond)
         COND_NONE:     cond_true = 1'b0;
         COND_DIV_BUSY: cond_true = div_status.busy;
         COND_OUT_FULL: cond_true = rsp_valid_ff && rsp_stall;
         default:       cond_true = 1'b0;
      endcase

      active_in    = active_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_angle_in = rsp_angle_ff;

      if (!active_ff) begin
         if (req_valid) begin
            active_in = 1'b1;
            step_in   = '0;
         end
      end else if (cond_true) begin
         step_in = uword.target;
      end else if (uword.finish) begin
         // output register is free or drains this cycle: load the result
         active_in    = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_angle_in = angle_ff;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   // configuration writes
   always_comb begin
      process_noise_in = process_noise_ff;
      meas_noise_in    = meas_noise_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PROCESS_NOISE:     process_noise_in = csr_data;
            CSR_MEASUREMENT_NOISE: meas_noise_in    = csr_data;
            default: ;
         endcase
      end
   end

   // shared multiplier operands
   always_comb begin
      dt_op = $signed({{(MUL_A_W-DT_W){1'b0}}, dt_ff});
      unique case (active_ff ? uword.mul_sel : MUL_NONE)
         MUL_DT_P11: begin
            mul_a = dt_op;
            mul_b = MUL_B_W'(p11_ff);
         end
         MUL_DT_INNER: begin
            mul_a = dt_op;
            mul_b = inner_ff;
         end
         MUL_K0_Y: begin
            mul_a = MUL_A_W'(div_status.k0);
            mul_b = MUL_B_W'(y_ff);
         end
         MUL_K1_P00: begin
            mul_a = MUL_A_W'(div_status.k1);
            mul_b = MUL_B_W'(p00_ff);
         end
         MUL_K1_P01: begin
            mul_a = MUL_A_W'(div_status.k1);
            mul_b = MUL_B_W'(p01_ff);
         end
         MUL_K0_P00: begin
            mul_a = MUL_A_W'(div_status.k0);
            mul_b = MUL_B_W'(p00_ff);
         end
         MUL_K0_P01: begin
            mul_a = MUL_A_W'(div_status.k0);
            mul_b = MUL_B_W'(p01_ff);
         end
         MUL_NONE: begin
            mul_a = '0;
            mul_b = '0;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // write-back of the product taken in the step before
   always_comb begin
      rnd16 = (prod_ff + RND16_HALF) >>> 16;
      rnd24 = (prod_ff + RND24_HALF) >>> 24;

      dt_in    = accept ? req_time_step : dt_ff;
      meas_in  = accept ? req_measured_angle : meas_ff;
      a_in     = a_ff;
      inner_in = inner_ff;
      y_in     = y_ff;
      angle_in = angle_ff;
      p00_in   = p00_ff;
      p01_in   = p01_ff;
      p10_in   = p10_ff;
      p11_in   = p11_ff;

      unique case (active_ff ? uword.wb_sel : WB_NONE)
         WB_NONE: ;
         WB_A:    a_in = rnd16[COV_W-1:0];
         WB_PRED: begin
            inner_in = MUL_B_W'(a_ff) - MUL_B_W'(p01_ff) - MUL_B_W'(p10_ff)
                     + $signed({{(MUL_B_W-NOISE_W){1'b0}}, process_noise_ff});
            p01_in   = sat32(PROD_W'(p01_ff) - PROD_W'(a_ff));
            p10_in   = sat32(PROD_W'(p10_ff) - PROD_W'(a_ff));
            y_in     = sat32(PROD_W'(meas_ff) - PROD_W'(angle_ff));
         end
         WB_P00_PRED: p00_in   = sat32(PROD_W'(p00_ff) + rnd16);
         WB_ANGLE:    angle_in = sat32(PROD_W'(angle_ff) + rnd24);
         WB_P10_UPD:  p10_in   = sat32(PROD_W'(p10_ff) - rnd24);
         WB_P11_UPD:  p11_in   = sat32(PROD_W'(p11_ff) - rnd24);
         WB_P00_UPD:  p00_in   = sat32(PROD_W'(p00_ff) - rnd24);
         WB_P01_UPD:  p01_in   = sat32(PROD_W'(p01_ff) - rnd24);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff        <= 1'b0;
         step_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
         process_noise_ff <= PROCESS_NOISE_RESET;
         meas_noise_ff    <= MEASUREMENT_NOISE_RESET;
         angle_ff         <= '0;
         p00_ff           <= '0;
         p01_ff           <= '0;
         p10_ff           <= '0;
         p11_ff           <= '0;
      end else begin
         active_ff        <= active_in;
         step_ff          <= step_in;
         rsp_valid_ff     <= rsp_valid_in;
         process_noise_ff <= process_noise_in;
         meas_noise_ff    <= meas_noise_in;
         angle_ff         <= angle_in;
         p00_ff           <= p00_in;
         p01_ff           <= p01_in;
         p10_ff           <= p10_in;
         p11_ff           <= p11_in;
      end
      rsp_angle_ff <= rsp_angle_in;
      dt_ff        <= dt_in;
      meas_ff      <= meas_in;
      a_ff         <= a_in;
      inner_ff     <= inner_in;
      y_ff         <= y_in;
      prod_ff      <= prod_in;
   end

endmodule

// ===== src/akf_checker.sv =====
// ----------------------------------------------------------------------------
// akf_checker
// Port-level checks on the angle Kalman filter, bound to the top level.
// ----------------------------------------------------------------------------
module akf_checker
   import akf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [ANGLE_W-1:0]  rsp_filtered_angle
);

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered_angle))
      else $error("stalled result changed or dropped");

   // an accepted request occupies the sequencer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted but block not busy");

   // a result only comes out of a running program
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised without work in flight");

   // leave reset idle and empty
   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_stall && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind angle_kalman_filter_top akf_checker u_akf_checker (.*);
